FILE: rtl/cdda_pkg.sv
// ----------------------------------------------------------------------------
// Civil date day arithmetic package
// Constants and small calendar functions shared by the date pipeline and
// its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdda_pkg;

   localparam logic [11:0] YEAR_MIN = 12'd1970;
   localparam logic [11:0] YEAR_MAX = 12'd3000;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   // Exact unsigned divide by 100 for any 32-bit operand: (x * magic) >> 37.
   localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
   localparam int          DIV100_SHIFT = 37;

   // Divide by 100 for any 12-bit operand: (x * 1311) >> 17.
   localparam logic [10:0] CENT_MAGIC = 11'd1311;
   localparam int          CENT_SHIFT = 17;

   // Exact divide by 7 for any 19-bit operand: (x * 599187) >> 22.
   localparam logic [19:0] DIV7_MAGIC = 20'd599187;
   localparam int          DIV7_SHIFT = 22;

   // Day count of 1970-01-01 in the March-based era scheme.
   localparam logic [21:0] EPOCH_OFFSET  = 22'd719468;
   // 1970-01-01 was a Thursday.
   localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;

   localparam logic [3:0]  WEEKDAY_INVALID = 4'hF;
   localparam logic [19:0] SPAN_INVALID    = 20'hFFFFF;

   // Quotient of a 12-bit year by 100, kept to five bits, so exact for years below 3200.
   function automatic logic [4:0] cent_of(logic [11:0] year);
      logic [22:0] prod;
      prod = 23'(year) * 23'(CENT_MAGIC);
      return prod[CENT_SHIFT +: 5];
   endfunction

   function automatic logic leap_year(logic [11:0] year, logic [4:0] cent);
      logic century;
      century = (year == 12'(12'(cent) * 12'd100));
      return (year[1:0] == 2'd0) && (!century || (cent[1:0] == 2'd0));
   endfunction

   // Length of a month; zero for a month number that means nothing.
   function automatic logic [4:0] month_days(logic [3:0] month, logic leap);
      logic [4:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // Days before the first of a month, counting the year from March 1.
   function automatic logic [8:0] march_offset(logic [3:0] month);
      logic [8:0] off;
      case (month)
         4'd3:    off = 9'd0;
         4'd4:    off = 9'd31;
         4'd5:    off = 9'd61;
         4'd6:    off = 9'd92;
         4'd7:    off = 9'd122;
         4'd8:    off = 9'd153;
         4'd9:    off = 9'd184;
         4'd10:   off = 9'd214;
         4'd11:   off = 9'd245;
         4'd12:   off = 9'd275;
         4'd1:    off = 9'd306;
         4'd2:    off = 9'd337;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

endpackage

FILE: rtl/civil_date_day_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Civil date day arithmetic unit
// Pipeline: each accepted transfer passes through seven pipeline stages and
// then the output register, which drives rsp_valid and the result.
// Throughput: one transfer per cycle; busy never rises, since the receiver
// cannot stall and every stage advances on every clock.
// Reset: synchronous and active high; it clears the stage valid bits and
// rsp_valid, so no result is issued for transfers in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module civil_date_day_arithmetic_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_first_date,
   input  logic [31:0]        req_second_date,
   input  logic [11:0]        req_query_year,
   input  logic [3:0]         req_query_month,
   output logic               rsp_valid,
   output logic signed [3:0]  rsp_first_weekday,
   output logic signed [3:0]  rsp_second_weekday,
   output logic signed [19:0] rsp_day_span,
   output logic [4:0]         rsp_month_length
);
   import cdda_pkg::*;

   localparam int LANES = 2;

   logic        accept;
   logic [7:1]  vld_ff;
   logic [31:0] date_in [LANES];

   // Stage 1: packed value divided by 100.
   logic [63:0] s1_prod [LANES];
   logic [25:0] s1_quot_in [LANES], s1_quot_ff [LANES];
   logic [6:0]  s1_low_in [LANES], s1_low_ff [LANES];
   logic [11:0] s1_qyear_ff;
   logic [3:0]  s1_qmonth_ff;
   logic [4:0]  s1_qcent_ff;

   // Stage 2: year and day.
   logic [63:0] s2_prod [LANES];
   logic [18:0] s2_year_in [LANES], s2_year_ff [LANES];
   logic [6:0]  s2_day_in [LANES], s2_day_ff [LANES];
   logic [6:0]  s2_qlo_ff [LANES];
   logic [4:0]  s2_qlen_in, s2_qlen_ff;

   // Stage 3: month, year range and century.
   logic [6:0]  s3_month_in [LANES], s3_month_ff [LANES];
   logic        s3_yok_in [LANES], s3_yok_ff [LANES];
   logic [11:0] s3_year_ff [LANES];
   logic [4:0]  s3_cent_in [LANES], s3_cent_ff [LANES];
   logic [6:0]  s3_day_ff [LANES];
   logic [4:0]  s3_qlen_ff;

   // Stage 4: validity, shifted year and day of year.
   logic [4:0]  s4_mlen [LANES];
   logic        s4_ok_in [LANES], s4_ok_ff [LANES];
   logic [11:0] s4_yy_in [LANES], s4_yy_ff [LANES];
   logic [8:0]  s4_doy_in [LANES], s4_doy_ff [LANES];
   logic [4:0]  s4_qlen_ff;

   // Stage 5: year terms of the day count.
   logic [20:0] s5_yy365_in [LANES], s5_yy365_ff [LANES];
   logic [9:0]  s5_yy4_ff [LANES];
   logic [4:0]  s5_cent_in [LANES], s5_cent_ff [LANES];
   logic [8:0]  s5_doy_ff [LANES];
   logic        s5_ok_ff [LANES];
   logic [4:0]  s5_qlen_ff;

   // Stage 6: day count offset by the epoch weekday.
   logic [21:0] s6_sum [LANES];
   logic [18:0] s6_cnt_in [LANES], s6_cnt_ff [LANES];
   logic        s6_ok_ff [LANES];
   logic [4:0]  s6_qlen_ff;

   // Stage 7: quotient by 7 and the span.
   logic [39:0] s7_prod [LANES];
   logic [15:0] s7_quot_in [LANES], s7_quot_ff [LANES];
   logic [2:0]  s7_low_ff [LANES];
   logic        s7_ok_ff [LANES];
   logic [19:0] s7_span_in, s7_span_ff;
   logic [4:0]  s7_qlen_ff;

   logic [2:0]  out_wd [LANES];
   logic [3:0]  out_wd_in [LANES];
   logic        rsp_valid_ff;
   logic [3:0]  rsp_wd_ff [LANES];
   logic [19:0] rsp_span_ff;
   logic [4:0]  rsp_len_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign date_in[0] = req_first_date;
   assign date_in[1] = req_second_date;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         s1_prod[l]    = 64'(date_in[l]) * 64'(DIV100_MAGIC);
         s1_quot_in[l] = s1_prod[l][DIV100_SHIFT +: 26];
         s1_low_in[l]  = date_in[l][6:0];

         s2_prod[l]    = 64'(s1_quot_ff[l]) * 64'(DIV100_MAGIC);
         s2_year_in[l] = s2_prod[l][DIV100_SHIFT +: 19];
         // The remainder is below 100, so seven low bits carry it exactly.
         s2_day_in[l]  = s1_low_ff[l] - 7'(s1_quot_ff[l][6:0] * 7'd100);

         s3_month_in[l] = s2_qlo_ff[l] - 7'(s2_year_ff[l][6:0] * 7'd100);
         s3_yok_in[l]   = (s2_year_ff[l] >= 19'(YEAR_MIN)) &&
                          (s2_year_ff[l] <= 19'(YEAR_MAX));
         s3_cent_in[l]  = cent_of(s2_year_ff[l][11:0]);

         s4_mlen[l]   = (s3_month_ff[l][6:4] == 3'd0)
                        ? month_days(s3_month_ff[l][3:0],
                                     leap_year(s3_year_ff[l], s3_cent_ff[l]))
                        : 5'd0;
         s4_ok_in[l]  = s3_yok_ff[l] && (s4_mlen[l] != 5'd0) &&
                        (s3_day_ff[l] != 7'd0) && (s3_day_ff[l] <= 7'(s4_mlen[l]));
         // January and February count as months of the previous year.
         s4_yy_in[l]  = s3_year_ff[l] -
                        12'(s3_month_ff[l][3:0] <= MONTH_FEB);
         s4_doy_in[l] = march_offset(s3_month_ff[l][3:0]) +
                        9'(s3_day_ff[l]) - 9'd1;

         s5_yy365_in[l] = 21'(s4_yy_ff[l]) * 21'd365;
         s5_cent_in[l]  = cent_of(s4_yy_ff[l]);

         s6_sum[l]    = 22'(s5_yy365_ff[l]) + 22'(s5_yy4_ff[l]) - 22'(s5_cent_ff[l])
                        + 22'(s5_cent_ff[l][4:2]) + 22'(s5_doy_ff[l])
                        - EPOCH_OFFSET + 22'(EPOCH_WEEKDAY);
         s6_cnt_in[l] = s6_sum[l][18:0];

         s7_prod[l]    = 40'(s6_cnt_ff[l]) * 40'(DIV7_MAGIC);
         s7_quot_in[l] = s7_prod[l][DIV7_SHIFT +: 16];

         out_wd[l]    = s7_low_ff[l] - 3'(s7_quot_ff[l][2:0] * 3'd7);
         out_wd_in[l] = s7_ok_ff[l] ? {1'b0, out_wd[l]} : WEEKDAY_INVALID;
      end

      if ((s1_qyear_ff >= YEAR_MIN) && (s1_qyear_ff <= YEAR_MAX)) begin
         s2_qlen_in = month_days(s1_qmonth_ff, leap_year(s1_qyear_ff, s1_qcent_ff));
      end else begin
         s2_qlen_in = 5'd0;
      end

      // Both counts carry the same epoch offset, so it drops out of the span.
      if (s6_ok_ff[0] && s6_ok_ff[1] && (s6_cnt_ff[1] >= s6_cnt_ff[0])) begin
         s7_span_in = 20'(s6_cnt_ff[1] - s6_cnt_ff[0]);
      end else begin
         s7_span_in = SPAN_INVALID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[6:1], accept};
         rsp_valid_ff <= vld_ff[7];
      end
   end

   always_ff @(posedge clock) begin
      s1_quot_ff   <= s1_quot_in;
      s1_low_ff    <= s1_low_in;
      s1_qyear_ff  <= req_query_year;
      s1_qmonth_ff <= req_query_month;
      s1_qcent_ff  <= cent_of(req_query_year);

      s2_year_ff <= s2_year_in;
      s2_day_ff  <= s2_day_in;
      s2_qlen_ff <= s2_qlen_in;
      for (int l = 0; l < LANES; l++) begin
         s2_qlo_ff[l] <= s1_quot_ff[l][6:0];
      end

      s3_month_ff <= s3_month_in;
      s3_yok_ff   <= s3_yok_in;
      s3_cent_ff  <= s3_cent_in;
      s3_day_ff   <= s2_day_ff;
      s3_qlen_ff  <= s2_qlen_ff;
      for (int l = 0; l < LANES; l++) begin
         s3_year_ff[l] <= s2_year_ff[l][11:0];
      end

      s4_ok_ff   <= s4_ok_in;
      s4_yy_ff   <= s4_yy_in;
      s4_doy_ff  <= s4_doy_in;
      s4_qlen_ff <= s3_qlen_ff;

      s5_yy365_ff <= s5_yy365_in;
      s5_cent_ff  <= s5_cent_in;
      s5_doy_ff   <= s4_doy_ff;
      s5_ok_ff    <= s4_ok_ff;
      s5_qlen_ff  <= s4_qlen_ff;
      for (int l = 0; l < LANES; l++) begin
         s5_yy4_ff[l] <= s4_yy_ff[l][11:2];
      end

      s6_cnt_ff  <= s6_cnt_in;
      s6_ok_ff   <= s5_ok_ff;
      s6_qlen_ff <= s5_qlen_ff;

      s7_quot_ff <= s7_quot_in;
      s7_ok_ff   <= s6_ok_ff;
      s7_span_ff <= s7_span_in;
      s7_qlen_ff <= s6_qlen_ff;
      for (int l = 0; l < LANES; l++) begin
         s7_low_ff[l] <= s6_cnt_ff[l][2:0];
      end

      rsp_wd_ff   <= out_wd_in;
      rsp_span_ff <= s7_span_ff;
      rsp_len_ff  <= s7_qlen_ff;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_first_weekday  = rsp_wd_ff[0];
   assign rsp_second_weekday = rsp_wd_ff[1];
   assign rsp_day_span       = rsp_span_ff;
   assign rsp_month_length   = rsp_len_ff;

endmodule

FILE: rtl/cdda_checker.sv
// ----------------------------------------------------------------------------
// Civil date day arithmetic checker
// Port-level assertions on result timing and on the consistency of the
// fields of each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdda_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [3:0]  rsp_first_weekday,
   input logic signed [3:0]  rsp_second_weekday,
   input logic signed [19:0] rsp_day_span,
   input logic [4:0]         rsp_month_length
);
   import cdda_pkg::*;

   // Every accepted transfer produces exactly one result.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##8 rsp_valid)
      else $error("accepted transfer produced no result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 8))
      else $error("result without a matching transfer");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_first_weekday == WEEKDAY_INVALID) ||
                     (rsp_second_weekday == WEEKDAY_INVALID)))
      |-> (rsp_day_span == SPAN_INVALID))
      else $error("span given for an invalid date");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (((rsp_first_weekday == WEEKDAY_INVALID) ||
                      (rsp_first_weekday[3:0] <= 4'd6)) &&
                     ((rsp_second_weekday == WEEKDAY_INVALID) ||
                      (rsp_second_weekday[3:0] <= 4'd6))))
      else $error("weekday out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_month_length == 5'd0) || (rsp_month_length >= 5'd28)))
      else $error("month length out of range");

endmodule

bind civil_date_day_arithmetic_unit cdda_checker u_cdda_checker (.*);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Civil date day arithmetic unit testbench
// Feeds pairs of packed YYYYMMDD dates and month-length queries into the unit.
// A predictor written in plain integer arithmetic works out the weekdays, the
// day span and the month length of every accepted transfer. Each strobed
// result is compared field by field against the oldest prediction. A directed
// set covers the calendar edges, and random phases with varied sender gaps
// follow it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   import cdda_pkg::*;

   localparam int unsigned ITEMS_PER_PHASE = 425;
   localparam int unsigned DRAIN_CYCLES    = 20;
   localparam int unsigned TIMEOUT_NS      = 2_000_000;

   typedef struct {
      logic [31:0] first_date;
      logic [31:0] second_date;
      logic [11:0] query_year;
      logic [3:0]  query_month;
      int unsigned idle_pct;
   } date_request_type;

   typedef struct {
      logic signed [3:0]  first_weekday;
      logic signed [3:0]  second_weekday;
      logic signed [19:0] day_span;
      logic [4:0]         month_length;
   } date_answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [31:0]        req_first_date = '0;
   logic [31:0]        req_second_date = '0;
   logic [11:0]        req_query_year = '0;
   logic [3:0]         req_query_month = '0;
   logic               rsp_valid;
   logic signed [3:0]  rsp_first_weekday;
   logic signed [3:0]  rsp_second_weekday;
   logic signed [19:0] rsp_day_span;
   logic [4:0]         rsp_month_length;

   date_request_type pending_requests[$];
   date_answer_type  expected_answers[$];
   int unsigned error_count = 0;
   int unsigned accepted_count = 0;
   int unsigned answers_checked = 0;
   int unsigned spans_measured = 0;

   civil_date_day_arithmetic_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_first_date     (req_first_date),
      .req_second_date    (req_second_date),
      .req_query_year     (req_query_year),
      .req_query_month    (req_query_month),
      .rsp_valid          (rsp_valid),
      .rsp_first_weekday  (rsp_first_weekday),
      .rsp_second_weekday (rsp_second_weekday),
      .rsp_day_span       (rsp_day_span),
      .rsp_month_length   (rsp_month_length)
   );

   always #10 clock = ~clock;

   // Days in a month, or zero when the year or month lies outside the calendar.
   function automatic logic [4:0] month_length_of(int unsigned year, int unsigned month);
      bit leap;
      if (month < 1 || month > 12 || year < YEAR_MIN || year > YEAR_MAX) return 5'd0;
      leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
      case (month)
         MONTH_FEB:   return leap ? 5'd29 : 5'd28;
         4, 6, 9, 11: return 5'd30;
         default:     return 5'd31;
      endcase
   endfunction

   function automatic bit split_packed_date(input logic [31:0] packed_date,
                                            output int unsigned year,
                                            output int unsigned month,
                                            output int unsigned day);
      logic [4:0] limit;
      year  = packed_date / 10000;
      month = (packed_date / 100) % 100;
      day   = packed_date % 100;
      limit = month_length_of(year, month);
      return limit != 0 && day >= 1 && day <= limit;
   endfunction

   // The count runs on a year that starts in March, so leap days fall at its end.
   function automatic int unsigned days_since_epoch(int unsigned year, int unsigned month,
                                                    int unsigned day);
      int unsigned y, era, yoe, doy, doe;
      y   = (month <= 2) ? year - 1 : year;
      era = y / 400;
      yoe = y - era * 400;
      doy = (153 * ((month > 2) ? month - 3 : month + 9) + 2) / 5 + day - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
   endfunction

   function automatic date_answer_type predict_date_answer(date_request_type r);
      date_answer_type a;
      int unsigned     fy, fm, fd, sy, sm, sd;
      int unsigned     fc, sc;
      bit              fv, sv;
      fv = split_packed_date(r.first_date, fy, fm, fd);
      sv = split_packed_date(r.second_date, sy, sm, sd);
      fc = fv ? days_since_epoch(fy, fm, fd) : 0;
      sc = sv ? days_since_epoch(sy, sm, sd) : 0;
      a.first_weekday  = fv ? 4'((fc + EPOCH_WEEKDAY) % 7) : WEEKDAY_INVALID;
      a.second_weekday = sv ? 4'((sc + EPOCH_WEEKDAY) % 7) : WEEKDAY_INVALID;
      a.day_span       = (fv && sv && sc >= fc) ? 20'(sc - fc) : SPAN_INVALID;
      a.month_length   = month_length_of(r.query_year, r.query_month);
      return a;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("ERROR at %0t ns: %s", $time, what);
   endtask

   task automatic add_request(input logic [31:0] first_date, input logic [31:0] second_date,
                              input logic [11:0] query_year, input logic [3:0] query_month,
                              input int unsigned idle_pct);
      date_request_type r;
      r.first_date  = first_date;
      r.second_date = second_date;
      r.query_year  = query_year;
      r.query_month = query_month;
      r.idle_pct    = idle_pct;
      pending_requests.push_back(r);
   endtask

   // Mostly real dates, with a share of broken days, months, years and raw noise.
   function automatic logic [31:0] random_packed_date();
      int unsigned y, m, d, kind;
      kind = $urandom_range(0, 99);
      y    = $urandom_range(1970, 3000);
      m    = $urandom_range(1, 12);
      d    = $urandom_range(1, 28);
      if (kind < 70) begin
         if ($urandom_range(0, 5) == 0) begin
            m = 32'(MONTH_FEB);
            y = 4 * $urandom_range(493, 750);
         end
         d = ($urandom_range(0, 3) == 0) ? 32'(month_length_of(y, m))
                                         : $urandom_range(1, month_length_of(y, m));
      end else if (kind < 80) begin
         d = $urandom_range(0, 1) ? 0 : $urandom_range(month_length_of(y, m) + 1, 99);
      end else if (kind < 88) begin
         m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
      end else if (kind < 94) begin
         y = $urandom_range(0, 1) ? $urandom_range(0, 1969) : $urandom_range(3001, 429495);
      end else begin
         return $urandom();
      end
      return y * 10000 + m * 100 + d;
   endfunction

   // Driver: a new transfer is offered at each falling edge unless the gap roll says idle.
   always @(negedge clock) begin
      if (reset || pending_requests.size() == 0) begin
         start <= 1'b0;
      end else if ($urandom_range(0, 99) < pending_requests[0].idle_pct) begin
         start <= 1'b0;
      end else begin
         start           <= 1'b1;
         req_first_date  <= pending_requests[0].first_date;
         req_second_date <= pending_requests[0].second_date;
         req_query_year  <= pending_requests[0].query_year;
         req_query_month <= pending_requests[0].query_month;
      end
   end

   // Monitor: the prediction is queued before the result check, so even a result
   // strobed in the same cycle as its transfer would find its expectation waiting.
   always @(posedge clock) begin
      date_request_type seen;
      date_answer_type  want;
      if (!reset) begin
         if (start && !busy) begin
            seen.first_date  = req_first_date;
            seen.second_date = req_second_date;
            seen.query_year  = req_query_year;
            seen.query_month = req_query_month;
            seen.idle_pct    = 0;
            expected_answers.push_back(predict_date_answer(seen));
            void'(pending_requests.pop_front());
            accepted_count++;
         end
         if (rsp_valid) begin
            if (expected_answers.size() == 0) begin
               report_mismatch("result strobed with no transfer outstanding");
            end else begin
               want = expected_answers.pop_front();
               answers_checked++;
               if (want.day_span != SPAN_INVALID) spans_measured++;
               if (rsp_first_weekday !== want.first_weekday)
                  report_mismatch($sformatf("first_weekday %0d, expected %0d",
                                            rsp_first_weekday, want.first_weekday));
               if (rsp_second_weekday !== want.second_weekday)
                  report_mismatch($sformatf("second_weekday %0d, expected %0d",
                                            rsp_second_weekday, want.second_weekday));
               if (rsp_day_span !== want.day_span)
                  report_mismatch($sformatf("day_span %0d, expected %0d",
                                            rsp_day_span, want.day_span));
               if (rsp_month_length !== want.month_length)
                  report_mismatch($sformatf("month_length %0d, expected %0d",
                                            rsp_month_length, want.month_length));
            end
         end
      end
   end

   initial begin
      logic [31:0] first_date, second_date, swap_date;
      logic [11:0] query_year;
      logic [3:0]  query_month;
      int unsigned idle_pct;

      // Calendar edges: full range span, reversed span, leap rules, broken fields.
      add_request(32'd19700101, 32'd30001231, 12'd1970, 4'd1, 0);
      add_request(32'd30001231, 32'd19700101, 12'd3000, 4'd2, 0);
      add_request(32'd19700101, 32'd19700101, 12'd0, 4'd0, 0);
      add_request(32'd20000229, 32'd21000229, 12'd2000, 4'd2, 0);
      add_request(32'd20240229, 32'd20230229, 12'd2100, 4'd2, 0);
      add_request(32'd19691231, 32'd30010101, 12'd1969, 4'd12, 0);
      add_request(32'd20240001, 32'd20241301, 12'd3001, 4'd1, 0);
      add_request(32'd20240100, 32'd20240132, 12'd4095, 4'd15, 0);
      add_request(32'd20240430, 32'd20240431, 12'd2024, 4'd4, 0);
      add_request(32'd0, 32'hFFFF_FFFF, 12'd2024, 4'd13, 0);
      add_request(32'd20240199, 32'd20249901, 12'd2400, 4'd2, 0);
      add_request(32'd20231231, 32'd20240101, 12'd2023, 4'd2, 0);
      add_request(32'd20240228, 32'd20240301, 12'd2024, 4'd2, 0);
      add_request(32'd29991231, 32'd30000101, 12'd2024, 4'd12, 0);
      add_request(32'd19700102, 32'd19700101, 12'd2024, 4'd0, 0);
      add_request(32'd24000229, 32'd19000229, 12'd1900, 4'd2, 0);
      add_request(32'd30000228, 32'd30000229, 12'd2024, 4'd11, 0);
      add_request(32'h8000_0000, 32'h7FFF_FFFF, 12'hAAA, 4'h5, 0);

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1) ? 69 : (phase == 2) ? 9 : 0;
         for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
            first_date  = random_packed_date();
            second_date = random_packed_date();
            if ($urandom_range(0, 9) == 0) begin
               second_date = first_date;
            end else if (first_date > second_date && $urandom_range(0, 9) < 7) begin
               swap_date   = first_date;
               first_date  = second_date;
               second_date = swap_date;
            end
            if ($urandom_range(0, 3) != 0) begin
               query_year  = 12'($urandom_range(1970, 3000));
               query_month = 4'($urandom_range(1, 12));
            end else begin
               query_year  = 12'($urandom_range(0, 4095));
               query_month = 4'($urandom_range(0, 15));
            end
            add_request(first_date, second_date, query_year, query_month, idle_pct);
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || expected_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Accepted %0d transfers and compared %0d results.",
               accepted_count, answers_checked);
      $display("%0d results carried a measured day span; %0d mismatches were found.",
               spans_measured, error_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timed out with %0d transfers pending and %0d results outstanding.",
               pending_requests.size(), expected_answers.size());
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: civil_date_day_arithmetic_unit.f
rtl/cdda_pkg.sv
rtl/civil_date_day_arithmetic_unit.sv
rtl/cdda_checker.sv
sim/testbench.sv
